FILE: rtl/core/sorted_table_binary_search_top_macros.svh
// assertion macros used by the sorted table search sequencer
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define STBS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stbs assertion failed");
// next-cycle implication, checked out of reset
`define STBS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stbs assertion failed");
`else
`define STBS_ASSERT_IMP(label, ante, cons)
`define STBS_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: rtl/core/stbs_pkg.sv
// types and constants for the sorted table search block
`default_nettype none
package stbs_pkg;

  localparam int CNT_W  = 11;
  localparam int SLOT_W = 10;
  localparam int KEY_W  = 64;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] position;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/core/sorted_table_binary_search_top.sv
// Sorted table binary search, top level.
//
// Input channel (in_valid/in_ready): in_operation selects a write beat, which
// stores in_key into table slot in_slot, or a search beat, which looks up in_key
// over slots 0 .. cfg entry_count-1. Writes to slots beyond the table are
// dropped. Write beats give no result.
// Result channel (out_valid/out_ready): one beat per search, out_found and
// out_position (0 when not found).
// cfg_we/cfg_wdata set entry_count; write it only while no search is in flight.
// The acceptance edge issues the first read of the key ram (registered read,
// one probe per cycle, at most 11 at a count of 1024); after the last probe
// the sequencer enters its done state, which hands the result to the output
// register once that register frees and then returns to idle, where the next
// beat is taken; a search holds the input until then.
// An empty table gives a miss without entering the probe state.
// Reset clears entry_count and the control state; table contents are undefined
// until written. A stalled receiver holds the output register; the next beat is
// still accepted, but a finished search waits until the output register frees.
`default_nettype none
module sorted_table_binary_search_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic        [stbs_pkg::CNT_W-1:0]  cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_operation,
  input  wire logic        [stbs_pkg::SLOT_W-1:0] in_slot,
  input  wire logic signed [stbs_pkg::KEY_W-1:0]  in_key,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_found,
  output logic             [stbs_pkg::SLOT_W-1:0] out_position
);
  import stbs_pkg::*;

  logic [CNT_W-1:0]  entry_count_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r;
  logic [SLOT_W-1:0] out_position_r;
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  stbs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .entry_count  (entry_count_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_slot      (in_slot),
    .in_key       (in_key),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // output register frees when empty or being taken
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        entry_count_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_found_r    <= res.found;
      out_position_r <= res.position;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

endmodule
`default_nettype wire

FILE: rtl/core/stbs_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module stbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/stbs_ctrl.sv
// search sequencer: key table memory, probe window and result register
`default_nettype none
`include "sorted_table_binary_search_top_macros.svh"
module stbs_ctrl #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic        [stbs_pkg::CNT_W-1:0]  entry_count,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_operation,
  input  wire logic        [stbs_pkg::SLOT_W-1:0] in_slot,
  input  wire logic signed [stbs_pkg::KEY_W-1:0]  in_key,
  output logic                                    res_valid,
  input  wire logic                               res_ready,
  output stbs_pkg::res_t                          res
);
  import stbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        lo_r, lo_nxt;
  logic [CNT_W-1:0]        hi_r, hi_nxt;
  logic [CNT_W-1:0]        mid_r, mid_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  res_t                    res_r, res_nxt;

  logic             ram_we;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [KEY_W-1:0] ram_rdata;

  logic [CNT_W-1:0] count_sat;
  logic [CNT_W-1:0] mid_init;
  logic [CNT_W-1:0] mid_plus;
  logic [CNT_W:0]   sum_right;
  logic [CNT_W:0]   sum_left;
  logic [CNT_W-1:0] mid_right;
  logic [CNT_W-1:0] mid_left;
  logic             slot_ok;
  logic             probe_eq;
  logic             probe_lt;
  logic             cont_right;
  logic             cont_left;
  logic             accept;

  // count above the table depth is clamped
  assign count_sat = (32'(entry_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : entry_count;
  assign slot_ok   = 32'(in_slot) < TABLE_DEPTH;
  assign accept    = in_valid && in_ready;

  // window is [lo, hi); middle = floor((lo + hi - 1) / 2)
  assign mid_init  = (count_sat - CNT_W'(1)) >> 1;
  assign mid_plus  = mid_r + CNT_W'(1);
  assign sum_right = {1'b0, mid_plus} + {1'b0, hi_r} - (CNT_W+1)'(1);
  assign sum_left  = {1'b0, lo_r} + {1'b0, mid_r} - (CNT_W+1)'(1);
  assign mid_right = sum_right[CNT_W:1];
  assign mid_left  = sum_left[CNT_W:1];

  assign probe_eq   = ram_rdata == key_r;
  assign probe_lt   = $signed(ram_rdata) < key_r;
  assign cont_right = mid_plus < hi_r;
  assign cont_left  = lo_r < mid_r;

  stbs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_slot)),
    .wdata (in_key),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_operation == OP_SEARCH) begin
          state_nxt = (count_sat == '0) ? ST_DONE : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (probe_eq) begin
          state_nxt = ST_DONE;
        end else if (probe_lt) begin
          state_nxt = cont_right ? ST_PROBE : ST_DONE;
        end else begin
          state_nxt = cont_left ? ST_PROBE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = AW'(mid_r);
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    key_nxt   = key_r;
    res_nxt   = res_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_operation == OP_WRITE) begin
            ram_we = slot_ok;
          end else begin
            key_nxt   = in_key;
            lo_nxt    = '0;
            hi_nxt    = count_sat;
            mid_nxt   = mid_init;
            ram_re    = 1'b1;
            ram_raddr = AW'(mid_init);
            res_nxt   = '0;
          end
        end
      end
      ST_PROBE: begin
        if (probe_eq) begin
          res_nxt.found    = 1'b1;
          res_nxt.position = mid_r[SLOT_W-1:0];
        end else if (probe_lt) begin
          lo_nxt    = mid_plus;
          mid_nxt   = mid_right;
          ram_re    = cont_right;
          ram_raddr = AW'(mid_right);
        end else begin
          hi_nxt    = mid_r;
          mid_nxt   = mid_left;
          ram_re    = cont_left;
          ram_raddr = AW'(mid_left);
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

  assign res = res_r;

  // probe address always lies inside the live window
  `STBS_ASSERT_IMP(a_mid_in_window, state_r == ST_PROBE, (lo_r <= mid_r) && (mid_r < hi_r))
  // a write beat never starts the sequencer
  `STBS_ASSERT_NXT(a_write_stays_idle, accept && in_operation == OP_WRITE, state_r == ST_IDLE)
  // a hit reports the slot that was probed
  `STBS_ASSERT_NXT(a_hit_position, state_r == ST_PROBE && probe_eq,
    state_r == ST_DONE && res_r.found && res_r.position == $past(mid_r[SLOT_W-1:0]))

endmodule
`default_nettype wire
